@@ hw/rtl/nsr_pkg.sv @@
// ----------------------------------------------------------------------------
// nsr_pkg: shared definitions for the Newton square root block
// Field widths, parameter defaults and the sequencer state type.
// ----------------------------------------------------------------------------
package nsr_pkg;

	localparam int SQUARE_W = 31;
	localparam int ROOT_W   = 32;
	localparam int TOL_W    = 32;
	localparam int GUESS_W  = 64;

	localparam int MAX_ITERATIONS_DEF = 32;
	localparam int FRAC_BITS_DEF      = 16;

	localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_CHECK
	} nsr_state_t;

endpackage

@@ hw/rtl/nsr_divider.sv @@
// ----------------------------------------------------------------------------
// nsr_divider: serial restoring divider
// Computes floor(square * 2^(2*FRAC_BITS) / divisor), one quotient bit per
// cycle, saturating to all ones when the quotient exceeds 64 bits.
// ----------------------------------------------------------------------------
module nsr_divider #(
	parameter int FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [nsr_pkg::SQUARE_W-1:0] square,
	input  logic [nsr_pkg::GUESS_W-1:0]  divisor,
	output logic                         busy,
	output logic                         done,
	output logic [nsr_pkg::GUESS_W-1:0]  quotient
);

	localparam int DW  = nsr_pkg::SQUARE_W + 2 * FRAC_BITS;
	localparam int GW  = nsr_pkg::GUESS_W;
	localparam int CW  = $clog2(DW + 1);

	logic [DW-1:0] dividend_q;
	logic [GW-1:0] rem_q;
	logic [GW-1:0] quo_q;
	logic          sat_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic [GW-1:0] divisor_eff;
	logic [GW:0]   rem_sh;
	logic [GW+1:0] diff;
	logic          fits;

	// The divisor is held stable by the sequencer for the whole division.
	assign divisor_eff = (divisor == '0) ? GW'(1) : divisor;
	assign rem_sh      = {rem_q, dividend_q[DW-1]};
	assign diff        = {1'b0, rem_sh} - {2'b00, divisor_eff};
	assign fits        = !diff[GW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dividend_q <= {square, {(2 * FRAC_BITS){1'b0}}};
			rem_q      <= '0;
			quo_q      <= '0;
			sat_q      <= 1'b0;
		end else if (cnt_q != '0) begin
			dividend_q <= {dividend_q[DW-2:0], 1'b0};
			rem_q      <= fits ? diff[GW-1:0] : rem_sh[GW-1:0];
			// A set top bit about to be shifted out means the quotient has
			// outgrown 64 bits.
			if (quo_q[GW-1]) begin
				sat_q <= 1'b1;
			end
			quo_q <= {quo_q[GW-2:0], fits};
		end
	end

	assign busy     = (cnt_q != '0);
	assign done     = done_q;
	assign quotient = sat_q ? {GW{1'b1}} : quo_q;

endmodule

@@ hw/rtl/newton_square_root.sv @@
// ----------------------------------------------------------------------------
// newton_square_root: fixed-point square root by Newton iteration
// Sequencer around one serial divider; one transaction in, one result out.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A request with a
// zero square_value or a zero tolerance answers on the next cycle with
// invalid_request set. Otherwise each Newton step is one division in the
// serial divider followed by a convergence check in the sequencer (the root is
// Q16.16 at the default FRAC_BITS), and the block runs between one and
// MAX_ITERATIONS steps depending on how fast the guess converges. The result
// is presented for exactly one cycle with done high and must be captured
// then, since the receiver cannot stall the block. The tolerance register is
// written with cfg_we and should only be changed while busy is low.
module newton_square_root #(
	parameter int MAX_ITERATIONS = nsr_pkg::MAX_ITERATIONS_DEF,
	parameter int FRAC_BITS      = nsr_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [nsr_pkg::SQUARE_W-1:0] square_value,
	input  logic                         cfg_we,
	input  logic [nsr_pkg::TOL_W-1:0]    cfg_data,
	output logic                         done,
	output logic [nsr_pkg::ROOT_W-1:0]   root,
	output logic                         invalid_request,
	output logic                         limit_reached
);

	localparam int GW = nsr_pkg::GUESS_W;
	localparam int SW = nsr_pkg::SQUARE_W;
	localparam int RW = nsr_pkg::ROOT_W;
	localparam int IW = $clog2(MAX_ITERATIONS);

	nsr_pkg::nsr_state_t state_q, state_d;

	logic [nsr_pkg::TOL_W-1:0] tolerance_q;
	logic [SW-1:0]             square_q;
	logic [GW-1:0]             guess_q;
	logic [GW-1:0]             next_q;
	logic [IW-1:0]             iter_q;
	logic                      done_q;
	logic [RW-1:0]             root_q;
	logic                      invalid_q;
	logic                      limit_q;
	logic                      first_div_q;

	logic          div_start;
	logic          kick;
	logic          div_busy;
	logic          div_done;
	logic [GW-1:0] div_quotient;
	logic          accept;
	logic          bad_request;
	logic [SW-2:0] first_half;
	logic [GW-1:0] first_guess;
	logic [GW:0]   pair_sum;
	logic [GW-1:0] deviation;
	logic          converged;
	logic          last_iter;

	assign accept      = start && (state_q == nsr_pkg::ST_IDLE);
	assign bad_request = (square_value == '0) || (tolerance_q == '0);
	assign first_half  = (square_value[SW-1:1] == '0) ? (SW-1)'(1) : square_value[SW-1:1];
	assign first_guess = GW'(first_half) << FRAC_BITS;
	assign pair_sum    = {1'b0, guess_q} + {1'b0, div_quotient};
	assign deviation   = (next_q >= guess_q) ? (next_q - guess_q) : (guess_q - next_q);
	assign converged   = (deviation <= GW'(tolerance_q));
	assign last_iter   = (iter_q == IW'(MAX_ITERATIONS - 1));

	// The divider is kicked either right after acceptance or from the check.
	assign kick = div_start || first_div_q;

	nsr_divider #(
		.FRAC_BITS(FRAC_BITS)
	) u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (kick),
		.square   (square_q),
		.divisor  (guess_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nsr_pkg::ST_IDLE;
			tolerance_q <= nsr_pkg::TOL_RESET;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (accept && bad_request) ||
			           (state_q == nsr_pkg::ST_CHECK && (converged || last_iter));
			if (cfg_we) begin
				tolerance_q <= cfg_data;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		unique case (state_q)
			nsr_pkg::ST_IDLE: begin
				if (start && !bad_request) begin
					state_d = nsr_pkg::ST_DIVIDE;
				end
			end
			nsr_pkg::ST_DIVIDE: begin
				if (div_done) begin
					state_d = nsr_pkg::ST_CHECK;
				end
			end
			nsr_pkg::ST_CHECK: begin
				if (converged || last_iter) begin
					state_d = nsr_pkg::ST_IDLE;
				end else begin
					state_d   = nsr_pkg::ST_DIVIDE;
					div_start = 1'b1;
				end
			end
			default: state_d = nsr_pkg::ST_IDLE;
		endcase
	end

	// The first division starts from the registered square and guess, in the
	// cycle after the transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_div_q <= 1'b0;
		end else begin
			first_div_q <= accept && !bad_request;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			square_q <= square_value;
			guess_q  <= first_guess;
			iter_q   <= '0;
			if (bad_request) begin
				root_q    <= '0;
				invalid_q <= 1'b1;
				limit_q   <= 1'b0;
			end
		end else if (state_q == nsr_pkg::ST_DIVIDE && div_done) begin
			next_q <= pair_sum[GW:1];
		end else if (state_q == nsr_pkg::ST_CHECK) begin
			guess_q <= next_q;
			iter_q  <= iter_q + IW'(1);
			if (converged || last_iter) begin
				root_q    <= (next_q[GW-1:RW] != '0) ? {RW{1'b1}} : next_q[RW-1:0];
				invalid_q <= 1'b0;
				limit_q   <= !converged;
			end
		end
	end

	assign busy            = (state_q != nsr_pkg::ST_IDLE);
	assign done            = done_q;
	assign root            = root_q;
	assign invalid_request = invalid_q;
	assign limit_reached   = limit_q;

	assert property (@(posedge clk) disable iff (!arst_n) done |-> !busy)
		else $error("result strobe while the sequencer is still busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		done && invalid_request |-> (root == '0) && !limit_reached)
		else $error("invalid request produced a nonzero root or a limit flag");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == nsr_pkg::ST_CHECK |-> !div_busy)
		else $error("convergence check while the divider is still running");

	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (square_value == '0) |=> done && invalid_request)
		else $error("zero square did not answer invalid on the next cycle");

endmodule
